FILE: design/clc_pkg.sv
// Shared constants and types for the card number check
package clc_pkg;
  localparam int unsigned NumW         = 63;
  localparam int unsigned DefMaxDigits = 19;
  localparam int unsigned CountW       = 5;
  localparam int unsigned SumW         = 8;
  // Decimal digits that a NumW-bit number can have, and their BCD width
  localparam int unsigned BcdDigits    = 19;
  localparam int unsigned BcdW         = 4 * BcdDigits;
  // Binary to BCD conversion: input bits handled per stage, and stage count
  localparam int unsigned BitsPerStage = 3;
  localparam int unsigned ConvStages   = NumW / BitsPerStage;
  localparam int unsigned ShW          = BcdW + NumW;

  typedef enum logic [1:0] {
    BRAND_INVALID = 2'd0,
    BRAND_A       = 2'd1,
    BRAND_B       = 2'd2,
    BRAND_C       = 2'd3
  } brand_e;
endpackage

FILE: design/card_number_luhn_classifier.sv
// Top level: pipelined Luhn check and brand classification of card numbers
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+----------------------
//  request   | card_number_i                           | start_i, busy_o
//  result    | brand_o, checksum_ok_o, digit_count_o   | done_o (one cycle)
//
// The number is turned into 19 BCD digits by shift-and-add-3 over 21 stages of
// three bits each. One stage then counts digits and forms partial Luhn sums, one
// adds the sums and picks the two leading digits, and the output stage classifies
// and registers the result on done_o. A new transaction enters every cycle; busy_o
// stays low. Reset clears only the valid bits. The receiver cannot stall.
module card_number_luhn_classifier
  import clc_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = DefMaxDigits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [NumW-1:0]   card_number_i,
  output logic              done_o,
  output logic [1:0]        brand_o,
  output logic              checksum_ok_o,
  output logic [CountW-1:0] digit_count_o
);

  localparam int unsigned NumGroups = (BcdDigits + 3) / 4;
  localparam int unsigned PadW      = 16 * NumGroups;
  localparam int unsigned PartW     = 6;

  // Three shift-and-add-3 steps on the BCD and binary halves
  function automatic logic [ShW-1:0] dabble3(logic [ShW-1:0] x);
    logic [ShW-1:0] s;
    s = x;
    for (int b = 0; b < BitsPerStage; b++) begin
      for (int j = 0; j < BcdDigits; j++) begin
        if (s[NumW+4*j +: 4] >= 4'd5) s[NumW+4*j +: 4] = s[NumW+4*j +: 4] + 4'd3;
      end
      s = {s[ShW-2:0], 1'b0};
    end
    return s;
  endfunction

  // Luhn contribution of one digit, doubled or as it is
  function automatic logic [3:0] luhn_add(logic [3:0] d, logic dbl);
    logic [4:0] p;
    logic [3:0] r;
    p = {d, 1'b0};
    if (!dbl) r = d;
    else r = (p > 5'd9) ? 4'(p - 5'd9) : p[3:0];
    return r;
  endfunction

  // True when the sum is a multiple of ten
  function automatic logic is_mult10(logic [SumW-1:0] s);
    logic r;
    r = 1'b0;
    for (int k = 0; k * 10 < (1 << SumW); k++) begin
      if (s == SumW'(k * 10)) r = 1'b1;
    end
    return r;
  endfunction

  logic [ConvStages:0] cv_vld_q;
  logic [ShW-1:0]      cv_sh_q [ConvStages+1];
  logic [ShW-1:0]      cv_sh_d [ConvStages+1];

  assign busy_o = 1'b0;

  // Load the entry stage
  assign cv_sh_d[0] = {BcdW'(0), card_number_i};

  // Convert three input bits per stage
  for (genvar g = 0; g < ConvStages; g++) begin : g_conv
    assign cv_sh_d[g+1] = dabble3(cv_sh_q[g]);
  end

  // Advance the conversion stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_vld_q <= '0;
    end else begin
      cv_vld_q <= {cv_vld_q[ConvStages-1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    cv_sh_q <= cv_sh_d;
  end

  // Count digits and form partial Luhn sums over groups of four digits
  logic [BcdW-1:0]   bcd;
  logic [PadW-1:0]   bcd_pad;
  logic [CountW-1:0] a_cnt_d;
  logic [PartW-1:0]  a_part_d [NumGroups];
  logic              a_vld_q;
  logic [BcdW-1:0]   a_bcd_q;
  logic [CountW-1:0] a_cnt_q;
  logic [PartW-1:0]  a_part_q [NumGroups];

  always_comb begin
    bcd     = cv_sh_q[ConvStages][ShW-1:NumW];
    bcd_pad = PadW'(bcd);
    a_cnt_d = '0;
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd[4*i +: 4] != 4'd0) a_cnt_d = CountW'(i + 1);
    end
    for (int g = 0; g < NumGroups; g++) begin
      a_part_d[g] = '0;
      for (int j = 0; j < 4; j++) begin
        a_part_d[g] = a_part_d[g] + PartW'(luhn_add(bcd_pad[16*g+4*j +: 4], j[0]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= cv_vld_q[ConvStages];
    end
  end

  always_ff @(posedge clk_i) begin
    a_bcd_q  <= bcd;
    a_cnt_q  <= a_cnt_d;
    a_part_q <= a_part_d;
  end

  // Add the partial sums and pick the two leading digits
  logic [BcdW+3:0]   lead_ext;
  logic [SumW-1:0]   b_sum_d;
  logic [3:0]        b_cur_d;
  logic [3:0]        b_prev_d;
  logic              b_vld_q;
  logic [SumW-1:0]   b_sum_q;
  logic [3:0]        b_cur_q;
  logic [3:0]        b_prev_q;
  logic [CountW-1:0] b_cnt_q;

  always_comb begin
    lead_ext = {a_bcd_q, 4'd0};
    b_sum_d  = '0;
    for (int g = 0; g < NumGroups; g++) begin
      b_sum_d = b_sum_d + SumW'(a_part_q[g]);
    end
    b_cur_d  = '0;
    b_prev_d = '0;
    for (int i = 0; i < BcdDigits; i++) begin
      if (a_cnt_q == CountW'(i + 1)) begin
        b_cur_d  = lead_ext[4*i+4 +: 4];
        b_prev_d = lead_ext[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_sum_q  <= b_sum_d;
    b_cur_q  <= b_cur_d;
    b_prev_q <= b_prev_d;
    b_cnt_q  <= a_cnt_q;
  end

  // Classify from the last stage
  logic              sat;
  logic              ok_d;
  logic [CountW-1:0] count_d;
  logic [6:0]        pair;
  brand_e            brand_d;
  logic              done_q;
  brand_e            brand_q;
  logic              ok_q;
  logic [CountW-1:0] count_q;

  always_comb begin
    sat     = b_cnt_q > CountW'(MAX_DIGITS);
    ok_d    = !sat && is_mult10(b_sum_q);
    count_d = sat ? CountW'(MAX_DIGITS) : b_cnt_q;
    pair    = 7'(b_cur_q) * 7'd10 + 7'(b_prev_q);
    priority if (!ok_d) begin
      brand_d = BRAND_INVALID;
    end else if (b_cnt_q == CountW'(15) && (pair == 7'd34 || pair == 7'd37)) begin
      brand_d = BRAND_A;
    end else if (b_cnt_q == CountW'(16) && pair > 7'd50 && pair < 7'd56) begin
      brand_d = BRAND_B;
    end else if ((b_cnt_q == CountW'(13) || b_cnt_q == CountW'(16)) && b_cur_q == 4'd4) begin
      brand_d = BRAND_C;
    end else begin
      brand_d = BRAND_INVALID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    brand_q <= brand_d;
    ok_q    <= ok_d;
    count_q <= count_d;
  end

  assign done_o        = done_q;
  assign brand_o       = brand_q;
  assign checksum_ok_o = ok_q;
  assign digit_count_o = count_q;

  // A brand needs a passing checksum
  a_brand_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && brand_o != BRAND_INVALID |-> checksum_ok_o)
    else $error("brand without checksum");
  // Count never exceeds the digit limit
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> digit_count_o <= CountW'(MAX_DIGITS))
    else $error("digit count too large");
  // Result follows the classify stage valid
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q |=> done_o)
    else $error("result lost");

endmodule
